[design/lstr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstr_pkg
// Shared types, constants and tables of the line sensor position tracker.
// ----------------------------------------------------------------------------
package lstr_pkg;

  localparam int SMP_W   = 8;
  localparam int NSENS   = 16;
  localparam int IDX_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int NUM_W   = 27;
  localparam int DEN_W   = 11;
  localparam int CNT_W   = 5;
  localparam int POS_W   = 16;
  localparam int MASK_W  = 16;
  localparam int CFG_W   = 8;
  localparam int ODATA_W = 96;

  localparam logic [1:0] LEARN_WHITE = 2'd1;
  localparam logic [1:0] LEARN_BLACK = 2'd2;

  localparam logic CFG_THRESH = 1'b0;
  localparam logic CFG_LEARN  = 1'b1;

  localparam logic [SMP_W-1:0] THRESH_RST = 8'd100;
  localparam logic [SMP_W-1:0] LEVEL_MAX  = 8'd255;

  localparam logic signed [POS_W-1:0] SENSOR_POS [NSENS] = '{
    -16'sd30000, -16'sd26000, -16'sd22000, -16'sd18000,
    -16'sd14000, -16'sd10000, -16'sd6000,  -16'sd2000,
    16'sd2000,   16'sd6000,   16'sd10000,  16'sd14000,
    16'sd18000,  16'sd22000,  16'sd26000,  16'sd30000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SDIV,
    ST_ACC,
    ST_CHK,
    ST_CDIV,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic [SMP_W-1:0] right;
    logic [SMP_W-1:0] left;
  } smp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [MASK_W-1:0] right_mask;
    logic [MASK_W-1:0] left_mask;
    logic [MASK_W-1:0] center_mask;
    logic [IDX_W-1:0]  window_last;
    logic [IDX_W-1:0]  window_first;
    logic [POS_W-1:0]  line_position;
    logic [MASK_W-1:0] line_bits;
    logic [SLOT_W-1:0] slot_index;
  } res_t;

endpackage

[design/lstr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstr_front
// Input side: takes sample beats and queues them for the back end.
// ----------------------------------------------------------------------------
module lstr_front import lstr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // left_sample, right_sample
  output logic        smp_valid_o,
  output smp_t        smp_o,
  input  logic        pop_i
);

  smp_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign smp_valid_o   = (cnt_q != 2'd0);
  assign smp_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= smp_t'(s_axis_tdata);
    end
  end

endmodule

[design/lstr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lstr_div import lstr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      den_d  = req_i.den;
      quo_d  = req_i.num;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[design/lstr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstr_back
// Sequencer: scales samples, learns white and black levels, updates the mask,
// accumulates the window centroid and holds the result beat.
// ----------------------------------------------------------------------------
module lstr_back import lstr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             smp_valid_i,
  input  smp_t             smp_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output res_t             out_o,
  input  logic             out_ready_i
);

  st_e               state_q, state_d;
  logic              ch_q, ch_d;
  logic [SMP_W-1:0]  l_q, l_d, r_q, r_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SMP_W-1:0]  thr_q;
  logic [1:0]        learn_q;
  logic [SMP_W-1:0]  level_q [NSENS];
  logic [SMP_W-1:0]  white_q [NSENS];
  logic [SMP_W-1:0]  black_q [NSENS];
  logic [MASK_W-1:0] mask_q, mask_d;
  logic signed [POS_W-1:0] last_pos_q, last_pos_d;
  logic signed [POS_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d, k_q, k_d;
  logic signed [NUM_W-1:0] wsum_q, wsum_d;
  logic [DEN_W-1:0]  nsum_q, nsum_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [IDX_W-1:0]  idx;
  logic [SMP_W-1:0]  raw, blk, wht, diff;
  logic [POS_W-1:0]  scaled;
  logic              commit_en;
  logic [SMP_W-1:0]  commit_lvl;
  logic              out_load;
  logic signed [24:0] prod_s;
  logic [NUM_W-1:0]  wabs;
  logic [POS_W-1:0]  pabs;
  logic [2:0]        pq;
  logic signed [5:0] lo_full, hi_full;
  logic [IDX_W-1:0]  lo_w, hi_w;
  logic [MASK_W-1:0] lmask, rmask;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  lstr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign idx    = {ch_q, slot_q};
  assign raw    = ch_q ? r_q : l_q;
  assign blk    = black_q[idx];
  assign wht    = white_q[idx];
  assign diff   = raw - blk;
  assign scaled = {diff, 8'h00} - {8'h00, diff};
  assign prod_s = SENSOR_POS[k_q] * $signed({1'b0, level_q[k_q]});
  assign wabs   = wsum_q[NUM_W-1] ? NUM_W'(-wsum_q) : NUM_W'(wsum_q);

  // window from last position: trunc(pos/4000) + 5 .. + 10, clamped
  always_comb begin
    pabs = last_pos_q[POS_W-1] ? POS_W'(-last_pos_q) : POS_W'(last_pos_q);
    pq   = 3'd0;
    for (int m = 1; m < 8; m++) begin
      if (pabs >= POS_W'(4000 * m)) begin
        pq = 3'(m);
      end
    end
    lo_full = last_pos_q[POS_W-1] ? 6'sd5 - $signed({3'b0, pq})
                                  : 6'sd5 + $signed({3'b0, pq});
    hi_full = lo_full + 6'sd5;
    lo_w    = lo_full[5] ? '0 : lo_full[IDX_W-1:0];
    hi_w    = (hi_full > 6'sd15) ? 4'd15 : hi_full[IDX_W-1:0];
  end

  assign lmask = MASK_W'(32'h0000ffff << (5'd16 - {1'b0, lo_q}));
  assign rmask = MASK_W'(32'h0000ffff >> ({1'b0, hi_q} + 5'd1));

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    l_d         = l_q;
    r_d         = r_q;
    slot_d      = slot_q;
    mask_d      = mask_q;
    last_pos_d  = last_pos_q;
    pos_d       = pos_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    wsum_d      = wsum_q;
    nsum_d      = nsum_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    div_req     = '0;
    commit_en   = 1'b0;
    commit_lvl  = '0;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (smp_valid_i) begin
          pop_o   = 1'b1;
          l_d     = smp_i.left;
          r_d     = smp_i.right;
          ch_d    = 1'b0;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (raw < blk) begin
          commit_en = 1'b1;
        end else if (raw > wht) begin
          commit_en  = 1'b1;
          commit_lvl = LEVEL_MAX;
        end else if (wht <= blk) begin
          commit_en = 1'b1;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(scaled);
          div_req.den   = DEN_W'(wht - blk);
          state_d       = ST_SDIV;
        end
      end
      ST_SDIV: begin
        if (div_rsp.done) begin
          commit_en  = 1'b1;
          commit_lvl = div_rsp.quo[SMP_W-1:0];
        end
      end
      ST_ACC: begin
        wsum_d = wsum_q + NUM_W'(prod_s);
        nsum_d = nsum_q + DEN_W'(level_q[k_q]);
        k_d    = k_q + 4'd1;
        if (k_q == hi_q) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (nsum_q == '0) begin
          pos_d   = '0;
          state_d = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = wabs;
          div_req.den   = nsum_q;
          state_d       = ST_CDIV;
        end
      end
      ST_CDIV: begin
        if (div_rsp.done) begin
          pos_d   = wsum_q[NUM_W-1] ? -$signed(div_rsp.quo[POS_W-1:0])
                                    : $signed(div_rsp.quo[POS_W-1:0]);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load                = 1'b1;
          out_d.slot_index        = slot_q;
          out_d.line_bits         = mask_q;
          out_d.line_position     = pos_q;
          out_d.window_first      = lo_q;
          out_d.window_last       = hi_q;
          out_d.center_mask       = ~(lmask | rmask);
          out_d.left_mask         = lmask;
          out_d.right_mask        = rmask;
          last_pos_d              = pos_q;
          slot_d                  = slot_q + 3'd1;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (commit_en) begin
      mask_d[~idx] = (commit_lvl > thr_q);
      if (!ch_q) begin
        ch_d    = 1'b1;
        state_d = ST_SCALE;
      end else begin
        lo_d    = lo_w;
        hi_d    = hi_w;
        k_d     = lo_w;
        wsum_d  = '0;
        nsum_d  = '0;
        state_d = ST_ACC;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      slot_q      <= '0;
      mask_q      <= '0;
      last_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      slot_q      <= slot_d;
      mask_q      <= mask_d;
      last_pos_q  <= last_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q    <= l_d;
    r_q    <= r_d;
    pos_q  <= pos_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    k_q    <= k_d;
    wsum_q <= wsum_d;
    nsum_q <= nsum_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESH_RST;
      learn_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESH: thr_q   <= cfg_data_i;
        CFG_LEARN:  learn_q <= cfg_data_i[1:0];
        default:    thr_q   <= thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSENS; i++) begin
        level_q[i] <= '0;
        white_q[i] <= '0;
        black_q[i] <= '0;
      end
    end else if (commit_en) begin
      level_q[idx] <= commit_lvl;
      if (learn_q == LEARN_WHITE && raw > wht) begin
        white_q[idx] <= raw;
      end
      if (learn_q == LEARN_BLACK && raw > blk) begin
        black_q[idx] <= raw;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[design/line_sensor_position_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_position_tracker
// Sixteen-sensor line tracker with a windowed weighted centroid.
// ----------------------------------------------------------------------------
// Each input beat carries the left and right samples of the current pair
// slot and yields one result beat. Sensor scalings with the sample between
// black and white, and the centroid with a nonzero level sum, go through one
// shared 27-step restoring divider; the window sum adds its sensors one by one.
// A two-beat input queue and an output register let both sides stall on
// their own. Peaks and levels clear at reset; no clearing pass is needed.
module line_sensor_position_tracker import lstr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // left_sample, right_sample
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // slot_index, line_bits, line_position, window_first, window_last,
  // center_mask, left_mask, right_mask, zero fill
  output logic [ODATA_W-1:0] m_axis_tdata
);

  logic smp_valid;
  smp_t smp;
  logic pop;
  res_t res;

  lstr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .smp_valid_o   (smp_valid),
    .smp_o         (smp),
    .pop_i         (pop)
  );

  lstr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .smp_valid_i (smp_valid),
    .smp_i       (smp),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_o       (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {5'b0, res};

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.window_last >= res.window_first))
    else $error("window bounds out of order");

  a_mask_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((res.center_mask & (res.left_mask | res.right_mask)) == '0
                       && res.center_mask != '0))
    else $error("window masks overlap or center empty");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(res.line_position) <= 16'sd30000
                       && $signed(res.line_position) >= -16'sd30000))
    else $error("position out of range");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> smp_valid)
    else $error("queue popped while empty");

endmodule
